FILE: hdl/fip_pkg.sv
// fip_pkg: widths, stage count and the pipeline stage record for fast_integer_power.
// Used by fip_stage and fast_integer_power; depends on nothing else.
`timescale 1ns / 1ps

package fip_pkg;

   // width of the arithmetic, results wrap modulo 2^DATA_WIDTH
   localparam int DATA_WIDTH = 32;
   localparam int BASE_WIDTH = 32;
   localparam int POWER_WIDTH = 32;
   localparam int EXP_BITS = 31;
   localparam int EXP_IDX_WIDTH = $clog2(EXP_BITS);
   // one square stage and one conditional multiply stage per exponent bit
   localparam int STAGES = 2 * EXP_BITS;

   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] base;
      logic [EXP_BITS-1:0]   exponent;
      logic [DATA_WIDTH-1:0] acc;
   } stage_type;

endpackage

FILE: hdl/fip_stage.sv
// fip_stage: one registered step of square-and-multiply, either a square of the
// running product or a multiply by the base when the selected exponent bit is set.
// Depends on fip_pkg.
`timescale 1ns / 1ps

module fip_stage import fip_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     square_mode,
   input  logic [EXP_IDX_WIDTH-1:0] bit_sel,
   input  stage_type                stage_d,
   output stage_type                stage_q
);

   stage_type             stage_ff;
   stage_type             stage_in;
   logic [DATA_WIDTH-1:0] operand;
   logic                  use_product;

   always_comb begin
      operand     = square_mode ? stage_d.acc : stage_d.base;
      use_product = square_mode | stage_d.exponent[bit_sel];
      stage_in    = stage_d;
      if (use_product) begin
         // only the low word of the product is kept
         stage_in.acc = DATA_WIDTH'(stage_d.acc * operand);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.base     <= stage_in.base;
      stage_ff.exponent <= stage_in.exponent;
      stage_ff.acc      <= stage_in.acc;
   end

   assign stage_q = stage_ff;

endmodule

FILE: hdl/fast_integer_power.sv
// fast_integer_power: pipelined square-and-multiply, signed base to a 31-bit exponent.
// Depends on fip_pkg and fip_stage.
//
//   channel   ports                          handshake
//   request   req_base, req_exponent         start high while busy low
//   response  rsp_power                      rsp_valid strobe, one cycle
//
// Each item passes through 62 multiply stages, one square and one conditional
// multiply per exponent bit; rsp_valid is the valid flag of the last stage.
// A new item can be taken in every cycle while busy is low; the pipeline never
// stalls; the receiver must take the result in its strobe cycle, which is not enforced.
// Reset empties the pipeline; busy is high for the cycle after reset is seen.
`timescale 1ns / 1ps

module fast_integer_power import fip_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [BASE_WIDTH-1:0] req_base,
   input  logic [EXP_BITS-1:0]          req_exponent,
   output logic                         rsp_valid,
   output logic signed [POWER_WIDTH-1:0] rsp_power
);

   logic      busy_ff;
   logic      busy_in;
   logic      accept;
   stage_type stage_bus [STAGES+1];

   assign busy_in = reset;
   assign accept  = start & ~busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   always_comb begin
      stage_bus[0].valid    = accept;
      stage_bus[0].base     = DATA_WIDTH'(req_base);
      stage_bus[0].exponent = req_exponent;
      stage_bus[0].acc      = DATA_WIDTH'(1);
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      fip_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .square_mode ((k % 2) == 0),
         .bit_sel     (EXP_IDX_WIDTH'(EXP_BITS - 1 - k / 2)),
         .stage_d     (stage_bus[k]),
         .stage_q     (stage_bus[k+1])
      );
   end

   assign busy      = busy_ff;
   assign rsp_valid = stage_bus[STAGES].valid;
   assign rsp_power = POWER_WIDTH'(stage_bus[STAGES].acc);

   // every result belongs to an item taken exactly one pipeline depth earlier
   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, STAGES))
      else $error("result without a matching item");

   // a zero exponent always yields one
   a_zero_exponent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stage_bus[STAGES].exponent == '0) |-> (rsp_power == POWER_WIDTH'(1)))
      else $error("zero exponent did not give one");

   // the block takes items again right after reset is released
   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> ##1 !busy)
      else $error("busy held after reset");

endmodule
